>>> rtl/core/rsnp_pkg.sv
package rsnp_pkg;

    localparam int PtW     = 16;
    localparam int CoordW  = 24;
    localparam int DirW    = 18;
    localparam int RsqW    = 48;
    localparam int LW      = 25;
    localparam int ProdW   = 43;
    localparam int SumW    = 52;
    localparam int DistW   = 48;
    localparam int TcaW    = 28;
    localparam int SqW     = 56;
    localparam int D2W     = 57;
    localparam int SqrtW   = 32;
    localparam int SqrtArgW = 64;

    localparam int RegOriginX = 0;
    localparam int RegOriginY = 1;
    localparam int RegOriginZ = 2;
    localparam int RegDirX    = 3;
    localparam int RegDirY    = 4;
    localparam int RegDirZ    = 5;
    localparam int RegRsq     = 6;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
        logic                     last_point;
    } rsnp_in_t;

    typedef struct packed {
        logic            hit_found;
        logic [PtW-1:0]  hit_index;
    } rsnp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_PROD,
        ST_SUM,
        ST_TCA,
        ST_D2,
        ST_SQRT,
        ST_UPDATE
    } rsnp_state_t;

    typedef struct packed {
        logic load;
        logic step_diff;
        logic step_prod;
        logic step_sum;
        logic step_tca;
        logic step_d2;
        logic sqrt_step;
        logic update;
    } rsnp_cmd_t;

    typedef struct packed {
        logic candidate;
        logic in_radius;
        logic sqrt_done;
        logic last;
    } rsnp_sts_t;

endpackage

>>> rtl/core/ray_sphere_nearest_pick.sv
// ray_sphere_nearest_pick
// Picks the point of a cloud nearest along a ray, each point taken as a
// small sphere of squared radius radius_sq.
// Input channel s_*: one request per point (Q8.16 position, last_point flag).
// Output channel m_*: one request per cloud, sent after the point marked
// last: hit_found and the index of the nearest hit (0 if none).
// APB port: registers origin_x/y/z, dir_x/y/z, radius_sq at 8*i; write only
// while idle.
// A point ends early if it lies behind the origin or outside the radius;
// one inside also runs the square root, 32 root-bit steps in one shared
// unit. One point at a time: a new point is taken only once the last one
// is through.
// The result sits in an output register; if the receiver stalls, the next
// cloud's points are still taken until another closing point arrives, which
// waits for the register to empty.
// Reset clears the accumulators, the output and restores register defaults.
module ray_sphere_nearest_pick
    import rsnp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  rsnp_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rsnp_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic signed [CoordW-1:0] ox_reg, oy_reg, oz_reg;
    logic signed [DirW-1:0]   dx_reg, dy_reg, dz_reg;
    logic [RsqW-1:0]          rsq_reg;
    rsnp_cmd_t cmd;
    rsnp_sts_t sts;
    rsnp_out_t res;
    rsnp_out_t out_reg;
    logic      out_vld_reg;
    logic      res_push, res_busy, wr_en;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign ridx   = paddr[5:3];

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_reg  <= '0;
            oy_reg  <= '0;
            oz_reg  <= '0;
            dx_reg  <= '0;
            dy_reg  <= '0;
            dz_reg  <= DirW'(65536);
            rsq_reg <= RsqW'(10737418);
        end else if (wr_en) begin
            case (ridx)
                3'(RegOriginX): ox_reg  <= pwdata[CoordW-1:0];
                3'(RegOriginY): oy_reg  <= pwdata[CoordW-1:0];
                3'(RegOriginZ): oz_reg  <= pwdata[CoordW-1:0];
                3'(RegDirX):    dx_reg  <= pwdata[DirW-1:0];
                3'(RegDirY):    dy_reg  <= pwdata[DirW-1:0];
                3'(RegDirZ):    dz_reg  <= pwdata[DirW-1:0];
                3'(RegRsq):     rsq_reg <= pwdata[RsqW-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (ridx)
            3'(RegOriginX): prdata = 64'($unsigned(ox_reg));
            3'(RegOriginY): prdata = 64'($unsigned(oy_reg));
            3'(RegOriginZ): prdata = 64'($unsigned(oz_reg));
            3'(RegDirX):    prdata = 64'($unsigned(dx_reg));
            3'(RegDirY):    prdata = 64'($unsigned(dy_reg));
            3'(RegDirZ):    prdata = 64'($unsigned(dz_reg));
            3'(RegRsq):     prdata = 64'(rsq_reg);
            default:        prdata = '0;
        endcase
    end

    // a closing point waits only while an earlier result is unread
    assign res_busy = out_vld_reg && s_data.last_point;

    rsnp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .res_busy (res_busy),
        .res_push (res_push),
        .sts      (sts),
        .cmd      (cmd)
    );

    rsnp_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .org_x   (ox_reg),
        .org_y   (oy_reg),
        .org_z   (oz_reg),
        .dir_x   (dx_reg),
        .dir_y   (dy_reg),
        .dir_z   (dz_reg),
        .rsq     (rsq_reg),
        .cmd     (cmd),
        .sts     (sts),
        .result  (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (res_push) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_push) out_reg <= res;
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

>>> rtl/core/rsnp_ctrl.sv
module rsnp_ctrl
    import rsnp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      res_busy,
    output logic      res_push,
    input  rsnp_sts_t sts,
    output rsnp_cmd_t cmd
);

    rsnp_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && !res_busy) state_next = ST_DIFF;
            end
            ST_DIFF: state_next = ST_PROD;
            ST_PROD: state_next = ST_SUM;
            ST_SUM:  state_next = ST_TCA;
            ST_TCA: begin
                state_next = sts.candidate ? ST_D2 : ST_UPDATE;
            end
            ST_D2: begin
                state_next = sts.in_radius ? ST_SQRT : ST_UPDATE;
            end
            ST_SQRT: begin
                if (sts.sqrt_done) state_next = ST_UPDATE;
            end
            ST_UPDATE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        res_push = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = !res_busy;
                cmd.load = s_valid && !res_busy;
            end
            ST_DIFF: cmd.step_diff = 1'b1;
            ST_PROD: cmd.step_prod = 1'b1;
            ST_SUM:  cmd.step_sum  = 1'b1;
            ST_TCA:  cmd.step_tca  = 1'b1;
            ST_D2:   cmd.step_d2   = 1'b1;
            ST_SQRT: cmd.sqrt_step = 1'b1;
            ST_UPDATE: begin
                cmd.update = 1'b1;
                res_push   = sts.last;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/core/rsnp_dpath.sv
module rsnp_dpath
    import rsnp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rsnp_in_t                 s_data,
    input  logic signed [CoordW-1:0] org_x,
    input  logic signed [CoordW-1:0] org_y,
    input  logic signed [CoordW-1:0] org_z,
    input  logic signed [DirW-1:0]   dir_x,
    input  logic signed [DirW-1:0]   dir_y,
    input  logic signed [DirW-1:0]   dir_z,
    input  logic [RsqW-1:0]          rsq,
    input  rsnp_cmd_t                cmd,
    output rsnp_sts_t                sts,
    output rsnp_out_t                result
);

    rsnp_in_t                  pt_reg;
    logic signed [LW-1:0]      lx_reg, ly_reg, lz_reg;
    logic signed [ProdW-1:0]   dx_reg, dy_reg, dz_reg;
    logic signed [2*LW-1:0]    qx_reg, qy_reg, qz_reg;
    logic signed [SumW-1:0]    tca32_reg, len2_reg;
    logic signed [DistW-1:0]   tca_reg;
    logic signed [D2W-1:0]     d2_reg;
    logic [SqrtArgW-1:0]       rem_reg, sres_reg, sbit_reg;
    logic [PtW-1:0]            cnt_reg, best_idx_reg;
    logic signed [DistW-1:0]   best_reg;
    logic                      any_reg;

    logic [TcaW-1:0]           tca_lo;
    logic [SqW-1:0]            tca_mul;
    logic signed [D2W-1:0]     d2_calc;
    logic signed [D2W-1:0]     rsq_ext;
    logic [SqrtArgW-1:0]       trial;
    logic signed [DistW-1:0]   t0;
    logic                      hit_now;

    // tca is non-negative and below 2^27 whenever it is squared
    assign tca_lo  = tca_reg[TcaW-1:0];
    assign tca_mul = SqW'(tca_lo) * SqW'(tca_lo);
    assign d2_calc = D2W'(len2_reg) - D2W'(tca_mul);
    assign rsq_ext = $signed({{(D2W-RsqW){1'b0}}, rsq});
    assign trial = sres_reg + sbit_reg;
    assign t0 = tca_reg - DistW'(sres_reg);
    assign hit_now = cmd.update && tca32_reg >= 0
                     && d2_reg <= rsq_ext && t0 < best_reg;

    assign sts.candidate = tca32_reg >= 0;
    assign sts.in_radius = d2_calc <= rsq_ext;
    assign sts.sqrt_done = sbit_reg[SqrtArgW-1:2] == '0;
    assign sts.last      = pt_reg.last_point;

    // payload pipeline: one step a state
    always_ff @(posedge aclk) begin
        if (cmd.load) pt_reg <= s_data;
        if (cmd.step_diff) begin
            lx_reg <= LW'(pt_reg.point_x) - LW'(org_x);
            ly_reg <= LW'(pt_reg.point_y) - LW'(org_y);
            lz_reg <= LW'(pt_reg.point_z) - LW'(org_z);
        end
        if (cmd.step_prod) begin
            dx_reg <= ProdW'(lx_reg) * ProdW'(dir_x);
            dy_reg <= ProdW'(ly_reg) * ProdW'(dir_y);
            dz_reg <= ProdW'(lz_reg) * ProdW'(dir_z);
            qx_reg <= (2*LW)'(lx_reg) * (2*LW)'(lx_reg);
            qy_reg <= (2*LW)'(ly_reg) * (2*LW)'(ly_reg);
            qz_reg <= (2*LW)'(lz_reg) * (2*LW)'(lz_reg);
        end
        if (cmd.step_sum) begin
            tca32_reg <= SumW'(dx_reg) + SumW'(dy_reg) + SumW'(dz_reg);
            len2_reg  <= SumW'(qx_reg) + SumW'(qy_reg) + SumW'(qz_reg);
        end
        if (cmd.step_tca) begin
            tca_reg  <= DistW'(tca32_reg >>> 16);
            sres_reg <= '0;
        end
        if (cmd.step_d2) begin
            d2_reg   <= d2_calc;
            sres_reg <= '0;
            sbit_reg <= SqrtArgW'(1) << 62;
            rem_reg  <= SqrtArgW'(rsq_ext - d2_calc);
        end
        // one bit of the root a cycle
        if (cmd.sqrt_step) begin
            if (rem_reg >= trial) begin
                rem_reg  <= rem_reg - trial;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end else begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
    end

    // accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            best_reg     <= {1'b0, {(DistW-1){1'b1}}};
            best_idx_reg <= '0;
            any_reg      <= 1'b0;
        end else if (cmd.update) begin
            if (pt_reg.last_point) begin
                cnt_reg      <= '0;
                best_reg     <= {1'b0, {(DistW-1){1'b1}}};
                best_idx_reg <= '0;
                any_reg      <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
                if (hit_now) begin
                    best_reg     <= t0;
                    best_idx_reg <= cnt_reg;
                    any_reg      <= 1'b1;
                end
            end
        end
    end

    // result for the closing point
    always_comb begin
        result.hit_found = any_reg || hit_now;
        result.hit_index = hit_now ? cnt_reg : (any_reg ? best_idx_reg : '0);
    end

endmodule
